// ===== src/iadp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package iadp_pkg;
    localparam int NUM_PROJECTS_DEF = 3;
    localparam int BUDGET_DEF = 7;
    localparam int PW = 5;
    localparam int AW = 4;
    localparam int GW = 16;
    localparam int TW = 20;

    typedef struct packed {
        logic [PW-1:0] project_index;
        logic [AW-1:0] amount;
        logic [GW-1:0] gain;
        logic          last_entry;
    } t_req;

    typedef struct packed {
        logic [PW-1:0] project_number;
        logic [AW-1:0] invested_amount;
        logic [TW-1:0] best_total;
        logic          last_result;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SOLVE,
        ST_TRACE
    } t_state;

    // what a cell sees from the sequencer in one solve step
    typedef struct packed {
        logic          clear;
        logic          load;
        logic [AW-1:0] k;
    } t_cell_ctl;
endpackage
`default_nettype wire

// ===== src/iadp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One budget column j. Per project it takes k = 0..J of the sequencer's sweep, taking the
// previous row's best at j-k from its left neighbor chain, and keeps the
// running best and choice. On load the running best becomes the row value.
module iadp_cell #(
    parameter int J = 1
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire iadp_pkg::t_cell_ctl   i_ctl,
    input  wire [iadp_pkg::TW-1:0]     i_prev_at,
    input  wire [iadp_pkg::GW-1:0]     i_gain,
    output logic [iadp_pkg::TW-1:0]    o_row,
    output logic [iadp_pkg::AW-1:0]    o_pick
);
    logic [iadp_pkg::TW-1:0] r_row, r_top;
    logic [iadp_pkg::AW-1:0] r_pick;
    logic [iadp_pkg::TW-1:0] n_sum;

    assign n_sum = i_prev_at + iadp_pkg::TW'(i_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_top  <= '0;
            r_pick <= '0;
        end else if (i_ctl.clear) begin
            r_top  <= '0;
            r_pick <= '0;
        end else if (i_ctl.load) begin
            r_row <= r_top;
        end else if ({1'b0, i_ctl.k} <= (iadp_pkg::AW+1)'(J)) begin
            if (n_sum > r_top) begin
                r_top  <= n_sum;
                r_pick <= i_ctl.k;
            end
        end
    end

    assign o_row  = r_row;
    assign o_pick = r_pick;
endmodule
`default_nettype wire

// ===== src/investment_allocation_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Loads one return entry per cycle while busy is low. An entry with last_entry
// set starts a solve: per project, a clear step, a sweep of k = 0..BUDGET
// across a row of BUDGET column cells, and a load step; then one result per
// cycle, last project first, each on the result ports for one cycle with
// o_valid high. The receiver cannot stall; busy stays high from the last
// entry until the final result has been shown.
module investment_allocation_dp #(
    parameter int NUM_PROJECTS = iadp_pkg::NUM_PROJECTS_DEF,
    parameter int BUDGET       = iadp_pkg::BUDGET_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  wire iadp_pkg::t_req i_req,
    output logic             o_valid,
    output iadp_pkg::t_res   o_res
);
    localparam int RL = BUDGET + 1;
    localparam int RB = $clog2(RL);
    localparam int PB = $clog2(NUM_PROJECTS + 1);
    localparam int TL = NUM_PROJECTS * RL;
    localparam int XB = (TL > 1) ? $clog2(TL) : 1;

    logic [iadp_pkg::GW-1:0] r_gain [TL];
    logic [iadp_pkg::AW-1:0] r_choice [TL];
    logic [iadp_pkg::TW-1:0] w_row [RL];
    logic [iadp_pkg::AW-1:0] w_pick [RL];

    iadp_pkg::t_state r_st, n_st;
    logic [PB-1:0] r_p;
    logic [iadp_pkg::AW:0] r_k;
    logic [1:0] r_ph;
    logic [iadp_pkg::AW-1:0] r_j;
    iadp_pkg::t_cell_ctl w_ctl;
    logic [iadp_pkg::GW-1:0] w_gk;
    logic [iadp_pkg::AW-1:0] w_c;
    logic acc;

    assign acc  = start && !busy;
    assign busy = (r_st != iadp_pkg::ST_IDLE);

    function automatic logic [XB-1:0] idx(input logic [PB-1:0] p, input logic [iadp_pkg::AW:0] a);
        idx = XB'(p * RL + a);
    endfunction

    assign w_ctl.clear = (r_st == iadp_pkg::ST_SOLVE) && (r_ph == 2'd0);
    assign w_ctl.load  = (r_st == iadp_pkg::ST_SOLVE) && (r_ph == 2'd2);
    assign w_ctl.k     = r_k[iadp_pkg::AW-1:0];
    assign w_gk = (r_k <= (iadp_pkg::AW+1)'(BUDGET)) ? r_gain[idx(r_p, r_k)] : '0;

    assign w_row[0]  = '0;
    assign w_pick[0] = '0;
    for (genvar j = 1; j < RL; j++) begin : g_cell
        logic [iadp_pkg::TW-1:0] w_prev;
        // previous row at j-k; first project sees an all-zero row,
        // invalid k is masked in the cell
        assign w_prev = (r_p != '0 && r_k <= (iadp_pkg::AW+1)'(j)) ?
                        w_row[RB'((iadp_pkg::AW+1)'(j) - r_k)] : '0;
        iadp_cell #(.J(j)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
            .i_prev_at(w_prev), .i_gain(w_gk),
            .o_row(w_row[j]), .o_pick(w_pick[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TL; i++) begin
                r_gain[i]   <= '0;
                r_choice[i] <= '0;
            end
        end else begin
            if (acc && i_req.project_index >= 5'd1 &&
                32'(i_req.project_index) <= NUM_PROJECTS &&
                32'(i_req.amount) <= BUDGET)
                r_gain[idx(PB'(i_req.project_index - 5'd1), {1'b0, i_req.amount})] <=
                    i_req.gain;
            if (w_ctl.load)
                for (int j = 0; j < RL; j++)
                    r_choice[idx(r_p, (iadp_pkg::AW+1)'(j))] <= w_pick[j];
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            iadp_pkg::ST_IDLE:  if (acc && i_req.last_entry) n_st = iadp_pkg::ST_SOLVE;
            iadp_pkg::ST_SOLVE: if (w_ctl.load && 32'(r_p) == NUM_PROJECTS - 1)
                                    n_st = iadp_pkg::ST_TRACE;
            iadp_pkg::ST_TRACE: if (r_p == '0) n_st = iadp_pkg::ST_IDLE;
            default:            n_st = iadp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= iadp_pkg::ST_IDLE;
            r_p  <= '0;
            r_k  <= '0;
            r_ph <= '0;
            r_j  <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                iadp_pkg::ST_IDLE: begin
                    r_p <= '0; r_k <= '0; r_ph <= 2'd0;
                end
                iadp_pkg::ST_SOLVE: begin
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else if (r_ph == 2'd1) begin
                        if (r_k == (iadp_pkg::AW+1)'(BUDGET)) r_ph <= 2'd2;
                        else r_k <= r_k + 1'b1;
                    end else begin
                        r_ph <= 2'd0; r_k <= '0;
                        if (32'(r_p) == NUM_PROJECTS - 1) r_j <= iadp_pkg::AW'(BUDGET);
                        else r_p <= r_p + 1'b1;
                    end
                end
                iadp_pkg::ST_TRACE: begin
                    r_j <= r_j - w_c;
                    r_p <= r_p - 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign w_c = r_choice[idx(r_p, {1'b0, r_j})];

    always_comb begin
        o_valid = (r_st == iadp_pkg::ST_TRACE);
        o_res.project_number  = iadp_pkg::PW'(r_p) + 5'd1;
        o_res.invested_amount = w_c;
        o_res.best_total      = w_row[BUDGET];
        o_res.last_result     = (r_p == '0);
    end
endmodule
`default_nettype wire

// ===== src/iadp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iadp_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire start,
    input wire busy,
    input wire o_valid,
    input wire iadp_pkg::t_res o_res
);
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while idle");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.last_result |=> !busy) else $error("busy after last result");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !start |=> !busy) else $error("busy without request");
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid) |-> $stable(o_res.best_total))
        else $error("total changed in run");
endmodule
bind investment_allocation_dp iadp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_res(o_res)
);
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import iadp_pkg::*;

    localparam int NPROJ = NUM_PROJECTS_DEF;
    localparam int BUD   = BUDGET_DEF;
    localparam int ROWS  = BUD + 1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_valid;
    t_res o_res;

    investment_allocation_dp uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_res(o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] gains [NPROJ][ROWS];
    t_res alloc_q[$];
    t_req pending_q[$];
    int mismatches = 0;
    int gap_left = 0;
    bit stim_done = 0;

    task automatic predict_request(input t_req r);
        logic [19:0] prev [ROWS];
        logic [19:0] cur [ROWS];
        logic [AW-1:0] pick_tab [NPROJ][ROWS];
        logic [19:0] top, v;
        logic [AW-1:0] pick;
        int j;
        t_res res;
        if (r.project_index >= 1 && r.project_index <= NPROJ && r.amount <= BUD)
            gains[r.project_index-1][r.amount] = r.gain;
        if (!r.last_entry) return;
        for (int b = 0; b < ROWS; b++) prev[b] = '0;
        for (int p = 0; p < NPROJ; p++) begin
            cur[0] = '0;
            pick_tab[p][0] = '0;
            for (int b = 1; b <= BUD; b++) begin
                top = '0;
                pick = '0;
                for (int k = 0; k <= b; k++) begin
                    v = prev[b-k] + gains[p][k];
                    if (v > top) begin
                        top = v;
                        pick = k[AW-1:0];
                    end
                end
                cur[b] = top;
                pick_tab[p][b] = pick;
            end
            prev = cur;
        end
        j = BUD;
        for (int p = NPROJ; p >= 1; p--) begin
            res.project_number  = p[PW-1:0];
            res.invested_amount = pick_tab[p-1][j];
            res.best_total      = prev[BUD];
            res.last_result     = (p == 1);
            alloc_q.push_back(res);
            j -= pick_tab[p-1][j];
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_request(i_req);
            end
            if (start && busy) begin
                // hold the request until it is taken
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_q.size() > 0) begin
                i_req <= pending_q.pop_front();
                start <= 1'b1;
                gap_left <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && o_valid) begin
            if (alloc_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_res);
            end else begin
                exp_res = alloc_q.pop_front();
                if (o_res !== exp_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_res, o_res);
                end
            end
        end
    end

    function automatic t_req make_req(int p, int a, int g, bit l);
        t_req r;
        r.project_index = p[PW-1:0];
        r.amount = a[AW-1:0];
        r.gain = g[GW-1:0];
        r.last_entry = l;
        return r;
    endfunction

    initial begin
        int total;
        for (int p = 0; p < NPROJ; p++)
            for (int a = 0; a < ROWS; a++) gains[p][a] = '0;
        // directed: all-zero solve, amount-0 gain, max gains, ties, out of range
        pending_q.push_back(make_req(1, 0, 0, 1));
        pending_q.push_back(make_req(2, 0, 16'hffff, 1));
        for (int a = 0; a <= BUD; a++) pending_q.push_back(make_req(1, a, 16'hffff, 0));
        pending_q.push_back(make_req(3, BUD, 16'hffff, 1));
        pending_q.push_back(make_req(2, 3, 16'h1234, 0));
        pending_q.push_back(make_req(3, 3, 16'h1234, 1));
        pending_q.push_back(make_req(0, 2, 16'h5555, 0));
        pending_q.push_back(make_req(31, 15, 16'haaaa, 0));
        pending_q.push_back(make_req(NPROJ + 1, 1, 16'h0001, 0));
        pending_q.push_back(make_req(2, 15, 16'h8000, 1));
        // random: mostly in range, some stray indexes and amounts, last every few entries
        total = 0;
        while (total < 260) begin
            int p, a;
            p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, NPROJ);
            a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, BUD);
            pending_q.push_back(make_req(p, a,
                ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 65535),
                $urandom_range(0, 5) == 0));
            total++;
        end
        pending_q.push_back(make_req(1, 1, 16'h0100, 1));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_q.size() == 0);
        @(posedge i_clk);
        while (start || busy || alloc_q.size() > 0) @(posedge i_clk);
        repeat (NPROJ * (BUD + 3) + NPROJ + 10) @(posedge i_clk);
        if (mismatches == 0 && alloc_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
src/iadp_pkg.sv
src/iadp_cell.sv
src/investment_allocation_dp.sv
src/iadp_checker.sv
tb/testbench.sv
